### rtl/indexed_list_store_core_assert.svh
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared concurrent assertion forms for the indexed list store checkers.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_CORE_ASSERT_SVH
`define INDEXED_LIST_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ILS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed list store: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ILS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed list store: next-cycle check failed");

`endif

### rtl/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store package
// Sizes, operation and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Number of entry cells in the chain.
   localparam int CAPACITY = 64;

   // Index into the chain, and a count that can also hold CAPACITY itself.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Fixed field widths.
   localparam int POS_W   = 7;
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int OCNT_W  = 7;

   // Common width for comparing a position with the count.
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 2'd0,
      MODE_READ   = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Per-cycle control broadcast along the chain.
   typedef struct packed {
      logic             append_en;
      logic             remove_en;
      logic             read_en;
      logic [IDX_W-1:0] append_index;
      logic [IDX_W-1:0] target_index;
   } cell_ctrl_type;

endpackage

### rtl/ils_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store entry cell
// Holds one entry; loads an appended value, or takes its upper neighbour's
// value when an entry at or below it is removed.
// ----------------------------------------------------------------------------
module ils_cell (
   input  logic                         clock,
   input  ils_pkg::cell_ctrl_type       ctrl,
   input  logic [ils_pkg::IDX_W-1:0]    cell_index,
   input  logic [ils_pkg::DATA_W-1:0]   write_value,
   input  logic [ils_pkg::DATA_W-1:0]   upper_value,
   output logic [ils_pkg::DATA_W-1:0]   value,
   output logic [ils_pkg::DATA_W-1:0]   read_data
);
   import ils_pkg::*;

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              load_en;

   // Select the new contents: append writes this cell only, remove shifts down.
   always_comb begin
      entry_in = entry_ff;
      load_en  = 1'b0;
      if (ctrl.append_en && (cell_index == ctrl.append_index)) begin
         entry_in = write_value;
         load_en  = 1'b1;
      end else if (ctrl.remove_en && (cell_index >= ctrl.target_index)) begin
         entry_in = upper_value;
         load_en  = 1'b1;
      end
   end

   // Entry storage needs no reset: it is only read after being written.
   always_ff @(posedge clock) begin
      if (load_en) begin
         entry_ff <= entry_in;
      end
   end

   assign value = entry_ff;

   // Drive the read bus only when this cell is the one addressed.
   assign read_data = (ctrl.read_en && (cell_index == ctrl.target_index)) ?
                      entry_ff : '0;

endmodule

### rtl/indexed_list_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store core
// Bounded ordered list of signed 32-bit values with append, read and remove.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low and
// returns its result item in the cycle after acceptance, from an output
// register that lets the next item be accepted in the cycle the current
// result is taken; req_stall rises only while a result is held and
// rsp_stall is high. The list lives in a chain of CAPACITY entry cells: a
// remove moves every cell above the position down one place in the same
// cycle, and a read selects the addressed cell onto a shared bus. No clearing
// pass runs after reset; the entry count alone says which cells are valid.
module indexed_list_store_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ils_pkg::MODE_W-1:0]    req_mode,
   input  logic [ils_pkg::POS_W-1:0]     req_position,
   input  logic signed [ils_pkg::DATA_W-1:0] req_write_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ils_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [ils_pkg::DATA_W-1:0] rsp_read_value,
   output logic [ils_pkg::OCNT_W-1:0]    rsp_entry_count
);
   import ils_pkg::*;

   logic                accept;
   logic                list_full;
   logic                pos_in_range;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    cnt_next_ext;
   status_type          status_in;
   cell_ctrl_type       ctrl;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic [DATA_W-1:0]   rsp_read_value_ff;
   logic [OCNT_W-1:0]   rsp_entry_count_ff;

   logic [DATA_W-1:0]   cell_value [CAPACITY];
   logic [DATA_W-1:0]   cell_read  [CAPACITY];
   logic [DATA_W-1:0]   read_bus;

   // An item enters whenever the output register is free or being emptied.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Range and capacity checks against the current count.
   assign pos_ext      = CMP_W'(req_position);
   assign cnt_ext      = CMP_W'(count_ff);
   assign pos_in_range = pos_ext < cnt_ext;
   assign list_full    = count_ff == CNT_W'(CAPACITY);

   // Decode the operation into cell controls, status and the next count.
   always_comb begin
      ctrl.append_en    = 1'b0;
      ctrl.remove_en    = 1'b0;
      ctrl.read_en      = 1'b0;
      ctrl.append_index = count_ff[IDX_W-1:0];
      ctrl.target_index = pos_ext[IDX_W-1:0];
      status_in         = ST_DONE;
      count_in          = count_ff;
      case (req_mode)
         MODE_APPEND: begin
            if (list_full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.append_en = accept;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         MODE_READ: begin
            if (!pos_in_range) begin
               status_in = ST_RANGE;
            end else begin
               ctrl.read_en = accept;
            end
         end
         MODE_REMOVE: begin
            if (!pos_in_range) begin
               status_in = ST_RANGE;
            end else begin
               ctrl.remove_en = accept;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // The chain of entry cells; the top cell refills from itself on a remove.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] upper;
      if (i == CAPACITY - 1) begin : g_top
         assign upper = cell_value[i];
      end else begin : g_mid
         assign upper = cell_value[i+1];
      end
      ils_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (IDX_W'(i)),
         .write_value (req_write_value),
         .upper_value (upper),
         .value       (cell_value[i]),
         .read_data   (cell_read[i])
      );
   end

   // At most one cell drives a non-zero word, so the read bus is an OR.
   always_comb begin
      read_bus = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_bus = read_bus | cell_read[i];
      end
   end

   // Output valid: set on acceptance, cleared once the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cnt_next_ext = CMP_W'(count_in);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff      <= status_in;
         rsp_read_value_ff  <= read_bus;
         rsp_entry_count_ff <= cnt_next_ext[OCNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

### rtl/ils_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store port checker
// Watches the top-level ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
`include "indexed_list_store_core_assert.svh"

module ils_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [ils_pkg::MODE_W-1:0]    req_mode,
   input  logic [ils_pkg::POS_W-1:0]     req_position,
   input  logic signed [ils_pkg::DATA_W-1:0] req_write_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [ils_pkg::STAT_W-1:0]    rsp_status,
   input  logic signed [ils_pkg::DATA_W-1:0] rsp_read_value,
   input  logic [ils_pkg::OCNT_W-1:0]    rsp_entry_count
);
   import ils_pkg::*;

   // A stalled result stays presented and unchanged.
   `ILS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) && $stable(rsp_entry_count))

   // A failed operation returns a zero read value.
   `ILS_ASSERT_NOW(a_value_zero, clock, reset, rsp_valid && (rsp_status != ST_DONE), rsp_read_value == '0)

   // A full report only comes with the list at capacity.
   `ILS_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_entry_count == OCNT_W'(CAPACITY))

   // The reported count never exceeds the capacity.
   `ILS_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, int'(rsp_entry_count) <= CAPACITY)

   // The block holds off the input only while a result is stalled.
   `ILS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (.*);
